[sv/pbeg_pkg.sv]
package pbeg_pkg;

  localparam int unsigned AtomCountDefault = 1024;
  localparam int unsigned GradW = 48;
  localparam int unsigned WordW = 3 * GradW;

  typedef logic signed [GradW-1:0] grad_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_ENE,
    S_EADD,
    S_MUL1,
    S_MUL2,
    S_GRAD,
    S_RD1,
    S_WR1,
    S_RD2,
    S_WR2,
    S_FIN,
    S_RRD,
    S_RWR
  } state_e;

  typedef enum logic [1:0] {
    CFG_CUTOFF_SQ  = 2'd0,
    CFG_INV_RADIUS = 2'd1,
    CFG_WEIGHT     = 2'd2,
    CFG_GRAD_EN    = 2'd3
  } cfg_idx_e;

  // a + b, clamped to the signed 48-bit range
  function automatic grad_t sat_add(grad_t a, logic signed [36:0] b);
    logic signed [48:0] s;
    s = {a[47], a} + {{12{b[36]}}, b};
    if (s[48] != s[47]) begin
      sat_add = s[48] ? {1'b1, {47{1'b0}}} : {1'b0, {47{1'b1}}};
    end else begin
      sat_add = s[47:0];
    end
  endfunction

endpackage

[sv/pair_bump_energy_gradient_top.sv]
// Bump energy and gradient accumulator.
// Pair word: an energy product, and in contact an energy add; with gradients on, two multiplies
// per axis, then a read-modify-write of each atom's entry in turn; then a finish step. Read word:
// a read, then a clearing write. One word in flight; a new word is taken only back in idle.
// A result sits in an output register; a word that ends with a result waits while it is full.
// Reset: async, active low; then a clearing pass over every entry zeroes
// the gradient store, during which no word is taken.
module pair_bump_energy_gradient_top #(
  parameter int unsigned ATOM_COUNT = pbeg_pkg::AtomCountDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_wdata_i,
  // input words
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                kind_i,
  input  logic [31:0]         dist_sq_i,
  input  logic [9:0]          seq_sep_i,
  input  logic signed [23:0]  x1_i,
  input  logic signed [23:0]  y1_i,
  input  logic signed [23:0]  z1_i,
  input  logic signed [23:0]  x2_i,
  input  logic signed [23:0]  y2_i,
  input  logic signed [23:0]  z2_i,
  input  logic [9:0]          index1_i,
  input  logic [9:0]          index2_i,
  input  logic                last_i,
  // result words
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                is_gradient_o,
  output logic [46:0]         total_energy_o,
  output logic signed [47:0]  grad_x_o,
  output logic signed [47:0]  grad_y_o,
  output logic signed [47:0]  grad_z_o
);
  import pbeg_pkg::*;

  localparam int unsigned AW = (ATOM_COUNT > 1) ? $clog2(ATOM_COUNT) : 1;

  // configuration registers
  logic [31:0] cutoff_q;
  logic [15:0] inv_r_q;
  logic [23:0] weight_q;
  logic        gen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= 32'd65536;
      inv_r_q  <= 16'd16384;
      weight_q <= 24'd65536;
      gen_q    <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CUTOFF_SQ:  cutoff_q <= cfg_wdata_i;
        CFG_INV_RADIUS: inv_r_q  <= cfg_wdata_i[15:0];
        CFG_WEIGHT:     weight_q <= cfg_wdata_i[23:0];
        CFG_GRAD_EN:    gen_q    <= cfg_wdata_i[0];
        default:        ;
      endcase
    end
  end

  // latched input word
  logic                kind_q, last_q;
  logic [31:0]         dsq_q;
  logic [9:0]          sep_q, i1_q, i2_q;
  logic signed [23:0]  x1_q, y1_q, z1_q, x2_q, y2_q, z2_q;

  state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [1:0]    axis_q, axis_d;

  logic [47:0]         eprod_q;
  logic [46:0]         esum_q, esum_d;
  logic signed [49:0]  p1_q;
  logic signed [50:0]  p2_q;
  logic signed [36:0]  g_q [3];

  logic out_valid_q, out_load, out_isg_d;
  logic [46:0] out_e_q, out_e_d;
  grad_t out_x_q, out_y_q, out_z_q, out_x_d, out_y_d, out_z_d;
  logic out_isg_q;

  logic accept;
  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      last_q <= last_i;
      dsq_q  <= dist_sq_i;
      sep_q  <= seq_sep_i;
      i1_q   <= index1_i;
      i2_q   <= index2_i;
      x1_q   <= x1_i;
      y1_q   <= y1_i;
      z1_q   <= z1_i;
      x2_q   <= x2_i;
      y2_q   <= y2_i;
      z2_q   <= z2_i;
    end
  end

  // index range checks and memory addresses
  logic [31:0] i1_ext, i2_ext;
  logic        ok1, ok2;
  logic [AW-1:0] a1, a2;
  assign i1_ext = 32'(i1_q);
  assign i2_ext = 32'(i2_q);
  assign ok1 = i1_ext < 32'(ATOM_COUNT);
  assign ok2 = i2_ext < 32'(ATOM_COUNT);
  assign a1  = i1_ext[AW-1:0];
  assign a2  = i2_ext[AW-1:0];

  logic contact;
  assign contact = (dsq_q < cutoff_q) && (sep_q > 10'd1);

  // per-axis coordinate difference
  logic signed [24:0] dif;
  always_comb begin
    case (axis_q)
      2'd0:    dif = {x1_q[23], x1_q} - {x2_q[23], x2_q};
      2'd1:    dif = {y1_q[23], y1_q} - {y2_q[23], y2_q};
      default: dif = {z1_q[23], z1_q} - {z2_q[23], z2_q};
    endcase
  end

  logic signed [33:0] qv;
  logic signed [36:0] gv;
  assign qv = 34'(p1_q >>> 16);
  assign gv = 37'(p2_q >>> 15);

  logic [47:0] esum_w;
  assign esum_w = {1'b0, esum_q} + {16'd0, eprod_q[47:16]};

  // gradient memory
  logic             m_we, m_re;
  logic [AW-1:0]    m_waddr, m_raddr;
  logic [WordW-1:0] m_wdata, m_rdata;
  grad_t            r_x, r_y, r_z;
  assign r_x = m_rdata[GradW-1:0];
  assign r_y = m_rdata[2*GradW-1:GradW];
  assign r_z = m_rdata[3*GradW-1:2*GradW];

  pbeg_grad_mem #(
    .Depth (ATOM_COUNT),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i (m_wdata),
    .re_i    (m_re),
    .raddr_i (m_raddr),
    .rdata_o (m_rdata)
  );

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    axis_d     = axis_q;
    esum_d     = esum_q;
    in_ready_o = 1'b0;
    m_we       = 1'b0;
    m_re       = 1'b0;
    m_waddr    = a1;
    m_raddr    = a1;
    m_wdata    = '0;
    out_load   = 1'b0;
    out_isg_d  = 1'b0;
    out_e_d    = '0;
    out_x_d    = '0;
    out_y_d    = '0;
    out_z_d    = '0;
    unique case (state_q)
      S_CLR: begin
        m_we    = 1'b1;
        m_waddr = clr_q;
        clr_d   = clr_q + 1'b1;
        if (32'(clr_q) == 32'(ATOM_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = kind_i ? S_RRD : S_ENE;
        end
      end
      S_ENE: begin
        axis_d  = 2'd0;
        state_d = contact ? S_EADD : S_FIN;
      end
      S_EADD: begin
        esum_d  = esum_w[47] ? {47{1'b1}} : esum_w[46:0];
        state_d = gen_q ? S_MUL1 : S_FIN;
      end
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_GRAD;
      S_GRAD: begin
        axis_d  = axis_q + 2'd1;
        state_d = (axis_q == 2'd2) ? S_RD1 : S_MUL1;
      end
      S_RD1: begin
        m_re    = 1'b1;
        state_d = S_WR1;
      end
      S_WR1: begin
        m_we    = ok1;
        m_wdata = {sat_add(r_z, -g_q[2]), sat_add(r_y, -g_q[1]), sat_add(r_x, -g_q[0])};
        state_d = S_RD2;
      end
      S_RD2: begin
        m_re    = 1'b1;
        m_raddr = a2;
        state_d = S_WR2;
      end
      S_WR2: begin
        m_we    = ok2;
        m_waddr = a2;
        m_wdata = {sat_add(r_z, g_q[2]), sat_add(r_y, g_q[1]), sat_add(r_x, g_q[0])};
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_load = 1'b1;
          out_e_d  = esum_q;
          esum_d   = '0;
          state_d  = S_IDLE;
        end
      end
      S_RRD: begin
        m_re    = 1'b1;
        state_d = S_RWR;
      end
      S_RWR: begin
        if (out_free) begin
          m_we      = ok1;
          out_load  = 1'b1;
          out_isg_d = 1'b1;
          out_x_d   = ok1 ? r_x : '0;
          out_y_d   = ok1 ? r_y : '0;
          out_z_d   = ok1 ? r_z : '0;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      axis_q      <= '0;
      esum_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      axis_q  <= axis_d;
      esum_q  <= esum_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath: one multiply per cycle, registered
  always_ff @(posedge clk_i) begin
    if (state_q == S_ENE) begin
      eprod_q <= (cutoff_q - dsq_q) * inv_r_q;
    end
    if (state_q == S_MUL1) begin
      p1_q <= dif * $signed({1'b0, weight_q});
    end
    if (state_q == S_MUL2) begin
      p2_q <= qv * $signed({1'b0, inv_r_q});
    end
    if (state_q == S_GRAD) begin
      g_q[2] <= gv;
      g_q[1] <= g_q[2];
      g_q[0] <= g_q[1];
    end
    if (out_load) begin
      out_isg_q <= out_isg_d;
      out_e_q   <= out_e_d;
      out_x_q   <= out_x_d;
      out_y_q   <= out_y_d;
      out_z_q   <= out_z_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign is_gradient_o  = out_isg_q;
  assign total_energy_o = out_e_q;
  assign grad_x_o       = out_x_q;
  assign grad_y_o       = out_y_q;
  assign grad_z_o       = out_z_q;

endmodule

[sv/pbeg_grad_mem.sv]
module pbeg_grad_mem #(
  parameter int unsigned Depth = pbeg_pkg::AtomCountDefault,
  parameter int unsigned AW    = 10
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [pbeg_pkg::WordW-1:0]  wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [pbeg_pkg::WordW-1:0]  rdata_o
);
  import pbeg_pkg::*;

  logic [WordW-1:0] mem [Depth];
  logic [WordW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[verif/pbeg_checker.sv]
module pbeg_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               kind_i,
  input  logic [31:0]        dist_sq_i,
  input  logic [9:0]         seq_sep_i,
  input  logic signed [23:0] x1_i,
  input  logic signed [23:0] y1_i,
  input  logic signed [23:0] z1_i,
  input  logic signed [23:0] x2_i,
  input  logic signed [23:0] y2_i,
  input  logic signed [23:0] z2_i,
  input  logic [9:0]         index1_i,
  input  logic [9:0]         index2_i,
  input  logic               last_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               is_gradient_i,
  input  logic [46:0]        total_energy_i,
  input  logic signed [47:0] grad_x_i,
  input  logic signed [47:0] grad_y_i,
  input  logic signed [47:0] grad_z_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 energy_seen_o,
  output int                 grad_seen_o
);
  import pbeg_pkg::*;

  localparam longint GMax = (64'sd1 <<< 47) - 1;
  localparam longint GMin = -(64'sd1 <<< 47);

  typedef struct packed {
    logic               is_grad;
    logic [46:0]        energy;
    logic signed [47:0] gx, gy, gz;
  } bump_result_t;

  logic [31:0] cutoff_q;
  logic [15:0] inv_rad_q;
  logic [23:0] weight_q;
  logic        grad_en_q;
  logic [46:0] energy_acc;
  longint      grad_mem [1024][3];
  bump_result_t expected_results [$];
  int mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = expected_results.size();

  function automatic longint clamp48(longint v);
    if (v > GMax) return GMax;
    if (v < GMin) return GMin;
    return v;
  endfunction

  // models one accepted word
  task automatic apply_word();
    bump_result_t r;
    longint d, q, g, e;
    logic [63:0] sum;
    longint c1 [3];
    longint c2 [3];
    c1[0] = x1_i; c1[1] = y1_i; c1[2] = z1_i;
    c2[0] = x2_i; c2[1] = y2_i; c2[2] = z2_i;
    r = '0;
    if (kind_i) begin
      r.is_grad = 1'b1;
      r.gx = grad_mem[index1_i][0];
      r.gy = grad_mem[index1_i][1];
      r.gz = grad_mem[index1_i][2];
      for (int a = 0; a < 3; a++) grad_mem[index1_i][a] = 0;
      expected_results.insert(expected_results.size(), r);
      return;
    end
    if (dist_sq_i < cutoff_q && seq_sep_i > 1) begin
      e = (longint'(cutoff_q - dist_sq_i) * longint'(inv_rad_q)) >>> 16;
      sum = {17'b0, energy_acc} + e;
      energy_acc = (sum > 64'h7FFF_FFFF_FFFF) ? '1 : sum[46:0];
      if (grad_en_q) begin
        for (int a = 0; a < 3; a++) begin
          d = c1[a] - c2[a];
          q = (d * longint'(weight_q)) >>> 16;
          g = (q * longint'(inv_rad_q)) >>> 15;
          grad_mem[index1_i][a] = clamp48(grad_mem[index1_i][a] - g);
          grad_mem[index2_i][a] = clamp48(grad_mem[index2_i][a] + g);
        end
      end
    end
    if (last_i) begin
      r.energy = energy_acc;
      energy_acc = '0;
      expected_results.insert(expected_results.size(), r);
    end
  endtask

  task automatic check_word();
    bump_result_t exp_r, got;
    got = '{is_gradient_i, total_energy_i, grad_x_i, grad_y_i, grad_z_i};
    if (got.is_grad) grad_seen_o++; else energy_seen_o++;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result word %p", got);
      return;
    end
    exp_r = expected_results.pop_front();
    if (got !== exp_r) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_r, got);
    end
  endtask

  initial begin
    mismatches = 0;
    energy_seen_o = 0;
    grad_seen_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q  <= 32'd65536;
      inv_rad_q <= 16'd16384;
      weight_q  <= 24'd65536;
      grad_en_q <= 1'b1;
      energy_acc = '0;
      for (int i = 0; i < 1024; i++)
        for (int a = 0; a < 3; a++) grad_mem[i][a] = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_word();
      if (in_valid_i && in_ready_i) apply_word();
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_CUTOFF_SQ:  cutoff_q  <= cfg_wdata_i;
          CFG_INV_RADIUS: inv_rad_q <= cfg_wdata_i[15:0];
          CFG_WEIGHT:     weight_q  <= cfg_wdata_i[23:0];
          CFG_GRAD_EN:    grad_en_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end
endmodule

[verif/pair_bump_energy_gradient_top_test.sv]
module pair_bump_energy_gradient_top_test;
  import pbeg_pkg::*;

  localparam int CycleLimit = 2_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic kind_i = 1'b0;
  logic [31:0] dist_sq_i = '0;
  logic [9:0] seq_sep_i = '0;
  logic signed [23:0] x1_i = '0, y1_i = '0, z1_i = '0;
  logic signed [23:0] x2_i = '0, y2_i = '0, z2_i = '0;
  logic [9:0] index1_i = '0, index2_i = '0;
  logic last_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic is_gradient_o;
  logic [46:0] total_energy_o;
  logic signed [47:0] grad_x_o, grad_y_o, grad_z_o;

  int fail_count, pending, energy_seen, grad_seen;
  int cycles = 0;
  int words_sent = 0;
  bit calm_tail = 0;      // no idling in the closing stretch
  bit long_hold = 0;      // receiver holds off to back up the block

  always #6 clk_i = ~clk_i;

  pair_bump_energy_gradient_top uut (.*);

  pbeg_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .kind_i, .dist_sq_i, .seq_sep_i,
    .x1_i, .y1_i, .z1_i, .x2_i, .y2_i, .z2_i, .index1_i, .index2_i, .last_i,
    .out_valid_i(out_valid_o), .out_ready_i, .is_gradient_i(is_gradient_o),
    .total_energy_i(total_energy_o), .grad_x_i(grad_x_o), .grad_y_i(grad_y_o),
    .grad_z_i(grad_z_o), .fail_count_o(fail_count), .pending_o(pending),
    .energy_seen_o(energy_seen), .grad_seen_o(grad_seen)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stall bursts, a long hold on request, none in the tail
  initial begin
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_ready_i <= 1'b0;
        repeat (400) @(negedge clk_i);
        long_hold = 0;
        out_ready_i <= 1'b1;
      end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // drop valid, wait for every result, then some slack for a word that produces none
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  // valid stays up after acceptance; the next word or a drain takes it down
  task automatic send_word(logic kind, logic [31:0] dsq, logic [9:0] sep,
                           logic [143:0] coords, logic [9:0] i1, logic [9:0] i2,
                           logic lst);
    bit took;
    @(negedge clk_i);
    if (!calm_tail && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind; dist_sq_i <= dsq; seq_sep_i <= sep;
    {x1_i, y1_i, z1_i, x2_i, y2_i, z2_i} <= coords;
    index1_i <= i1; index2_i <= i2; last_i <= lst;
    // ready follows the state register only, so it is settled at the falling edge
    took = in_ready_o;
    @(posedge clk_i);
    while (!took) begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end
    words_sent++;
  endtask

  function automatic logic [143:0] rand_coords(bit wide);
    logic [143:0] c;
    for (int k = 0; k < 6; k++)
      c[k*24 +: 24] = wide ? 24'($urandom) : 24'($urandom_range(0, 16383) - 8192);
    return c;
  endfunction

  // mostly pairs in contact on a small atom set, with reads and pass ends
  task automatic random_word();
    int sel;
    logic [31:0] dsq;
    sel = $urandom_range(0, 99);
    dsq = (sel < 70) ? 32'($urandom_range(0, 70000)) : $urandom;
    if (sel < 15)
      send_word(1'b1, $urandom, 10'($urandom), rand_coords(1),
                10'($urandom_range(0, 31)), 10'($urandom), 1'($urandom));
    else
      send_word(1'b0, dsq, (sel < 85) ? 10'($urandom_range(2, 1023)) : 10'($urandom),
                rand_coords(sel > 90), 10'($urandom_range(0, 31)),
                (sel == 99) ? 10'($urandom) : 10'($urandom_range(0, 31)),
                $urandom_range(0, 9) == 0);
  endtask

  initial begin
    logic [143:0] ext;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: edges and every special case
    ext = {24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000};
    send_word(1'b0, 32'd0, 10'd2, ext, 10'd5, 10'd6, 1'b0);
    send_word(1'b0, 32'd100, 10'd1023, ext, 10'd7, 10'd7, 1'b0);      // same atom twice
    send_word(1'b0, 32'd10, 10'd1, ext, 10'd5, 10'd6, 1'b0);          // adjacent residues
    send_word(1'b0, 32'd65536, 10'd5, ext, 10'd5, 10'd6, 1'b0);       // at cutoff
    send_word(1'b0, 32'hFFFFFFFF, 10'd0, ext, 10'd1023, 10'd0, 1'b1); // miss, still emits
    send_word(1'b1, 32'd0, 10'd0, '0, 10'd5, 10'd0, 1'b1);            // read, last ignored
    send_word(1'b1, 32'd0, 10'd0, '0, 10'd6, 10'd0, 1'b0);
    send_word(1'b1, 32'd0, 10'd0, '0, 10'd7, 10'd0, 1'b0);
    send_word(1'b1, 32'd0, 10'd0, '0, 10'd5, 10'd0, 1'b0);            // already cleared
    send_word(1'b1, 32'd0, 10'd0, '0, 10'd1023, 10'd0, 1'b0);
    drain();

    // extreme settings: big cutoff, inverse radius and weight give the largest per-word terms
    write_reg(CFG_CUTOFF_SQ, 32'hFFFFFFFF);
    write_reg(CFG_INV_RADIUS, 32'd65535);
    write_reg(CFG_WEIGHT, 32'hFFFFFF);
    for (int k = 0; k < 12; k++)
      send_word(1'b0, 32'd0, 10'd3, ext, 10'd9, 10'd10, k == 11);
    send_word(1'b1, 32'd0, 10'd0, '0, 10'd9, 10'd0, 1'b0);
    send_word(1'b1, 32'd0, 10'd0, '0, 10'd10, 10'd0, 1'b0);
    drain();

    // random phases across several settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(CFG_INV_RADIUS, 32'd1); write_reg(CFG_GRAD_EN, 32'd0); end
        1: begin write_reg(CFG_CUTOFF_SQ, 32'd0); write_reg(CFG_GRAD_EN, 32'd1); end
        2: begin write_reg(CFG_CUTOFF_SQ, 32'd65536); write_reg(CFG_INV_RADIUS, 32'd16384);
                 write_reg(CFG_WEIGHT, 32'd0); end
        3: write_reg(CFG_WEIGHT, 32'($urandom));
        default: write_reg(CFG_WEIGHT, 32'd65536);
      endcase
      if (ph == 2) begin
        long_hold = 1;  // back up the result side while words keep coming
        for (int k = 0; k < 20; k++) random_word();
      end
      if (ph == 4) calm_tail = 1;
      for (int k = 0; k < 200; k++) random_word();
      drain();          // sender pauses until all results are in
    end

    repeat (50) @(negedge clk_i);
    $display("%0d words sent, %0d energy and %0d gradient results checked",
             words_sent, energy_seen, grad_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
